>>> design/o3wd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// o3wd_pkg: shared types and constants of the omni wheel drive
// Holds widths, register indexes, kinematic coefficients and the output clamp.
// ----------------------------------------------------------------------------
package o3wd_pkg;

  localparam int Wheels = 3;

  localparam int VelW    = 13;
  localparam int MeasW   = 14;
  localparam int SpW     = 16;
  localparam int ErrW    = 16;
  localparam int DiffW   = 17;
  localparam int GainW   = 16;
  localparam int IntegW  = 19;
  localparam int MagW    = 10;
  localparam int CfgIdxW = 2;

  localparam int PW   = GainW + 1 + ErrW;   // proportional and integral products
  localparam int DW   = GainW + 1 + DiffW;  // derivative product
  localparam int PdW  = DW + 1;             // P + D
  localparam int SumW = PdW + 1;            // P + D + integral

  // Q1.14 kinematic coefficients.
  localparam int KinW     = 29;
  localparam int CoefSin  = 14189;
  localparam int CoefFrac = 14;

  localparam int LimitQ8 = 999 * 256;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP  = 2'd0,
    REG_INTEG = 2'd1,
    REG_DERIV = 2'd2,
    REG_NONE  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [GainW-1:0] kp;
    logic [GainW-1:0] ki;
    logic [GainW-1:0] kd;
  } gains_t;

  // Load enables of the lane pipeline stages.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } lane_ctrl_t;

  function automatic logic signed [IntegW-1:0] clamp_q8(input logic signed [SumW-1:0] v);
    logic signed [IntegW-1:0] r;
    if (v > SumW'(LimitQ8)) begin
      r = IntegW'(LimitQ8);
    end else if (v < -SumW'(LimitQ8)) begin
      r = -IntegW'(LimitQ8);
    end else begin
      r = v[IntegW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/o3wd_kin.sv
`default_nettype none
// ----------------------------------------------------------------------------
// o3wd_kin: inverse kinematics and wheel setpoint registers
// Turns x, y and angular velocity into three wheel setpoints for wheels at
// 300, 60 and 180 degrees, dividing by 2^14 with truncation toward zero.
// ----------------------------------------------------------------------------
module o3wd_kin (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                load_i,
  input  wire logic signed [o3wd_pkg::VelW-1:0]    vel_x_i,
  input  wire logic signed [o3wd_pkg::VelW-1:0]    vel_y_i,
  input  wire logic signed [o3wd_pkg::VelW-1:0]    vel_turn_i,
  output logic signed [o3wd_pkg::SpW-1:0]          setpoint_o [o3wd_pkg::Wheels]
);

  localparam int KW = o3wd_pkg::KinW;
  localparam int QW = KW - o3wd_pkg::CoefFrac;

  logic signed [KW-1:0] x_ext, y_ext, w_ext, x_term, common, sum_a, sum_b;
  logic signed [o3wd_pkg::VelW:0] diff_c;
  logic signed [o3wd_pkg::SpW-1:0] setpoint_d [o3wd_pkg::Wheels];
  logic signed [o3wd_pkg::SpW-1:0] setpoint_q [o3wd_pkg::Wheels];

  function automatic logic signed [QW-1:0] q14_trunc(input logic signed [KW-1:0] v);
    logic signed [QW-1:0] q;
    q = v[KW-1:o3wd_pkg::CoefFrac];
    // An arithmetic shift floors; negative values with a remainder move up by one.
    if (v[KW-1] && (|v[o3wd_pkg::CoefFrac-1:0])) begin
      q = q + QW'(1);
    end
    return q;
  endfunction

  always_comb begin
    x_ext  = KW'(vel_x_i);
    y_ext  = KW'(vel_y_i);
    w_ext  = KW'(vel_turn_i);
    x_term = x_ext * KW'(o3wd_pkg::CoefSin);
    common = (y_ext <<< (o3wd_pkg::CoefFrac - 1)) + (w_ext <<< o3wd_pkg::CoefFrac);
    sum_a  = common + x_term;
    sum_b  = common - x_term;
    // The third wheel divides exactly: its terms are all whole multiples of 2^14.
    diff_c = (o3wd_pkg::VelW+1)'(vel_turn_i) - (o3wd_pkg::VelW+1)'(vel_y_i);
    setpoint_d[0] = o3wd_pkg::SpW'(q14_trunc(sum_a));
    setpoint_d[1] = o3wd_pkg::SpW'(q14_trunc(sum_b));
    setpoint_d[2] = o3wd_pkg::SpW'(diff_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < o3wd_pkg::Wheels; i++) begin
        setpoint_q[i] <= '0;
      end
    end else if (load_i) begin
      setpoint_q <= setpoint_d;
    end
  end

  assign setpoint_o = setpoint_q;

endmodule
`default_nettype wire

>>> design/o3wd_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// o3wd_lane: PID pipeline for one wheel
// Stage 1 forms the error and its change, stage 2 the three gain products,
// stage 3 the clamped integral and P + D; the clamped drive value follows.
// ----------------------------------------------------------------------------
module o3wd_lane (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire o3wd_pkg::lane_ctrl_t                ctrl_i,
  input  wire o3wd_pkg::gains_t                    gains_i,
  input  wire logic signed [o3wd_pkg::SpW-1:0]     setpoint_i,
  input  wire logic signed [o3wd_pkg::MeasW-1:0]   meas_i,
  output logic                                     dir_o,
  output logic [o3wd_pkg::MagW-1:0]                mag_o
);

  localparam int ErrW   = o3wd_pkg::ErrW;
  localparam int DiffW  = o3wd_pkg::DiffW;
  localparam int PW     = o3wd_pkg::PW;
  localparam int DW     = o3wd_pkg::DW;
  localparam int PdW    = o3wd_pkg::PdW;
  localparam int SumW   = o3wd_pkg::SumW;
  localparam int IntegW = o3wd_pkg::IntegW;

  logic signed [ErrW-1:0]   err_d, err_q, last_err_q;
  logic signed [DiffW-1:0]  diff_d, diff_q;
  logic signed [PW-1:0]     p_d, p_q, i_d, i_q;
  logic signed [DW-1:0]     dprod_d, dprod_q;
  logic signed [PdW-1:0]    pd_d, pd_q;
  logic signed [SumW-1:0]   acc_sum, out_sum;
  logic signed [IntegW-1:0] integ_d, integ_q, drive;
  logic [IntegW-2:0]        drive_abs;

  always_comb begin
    err_d   = setpoint_i - ErrW'(meas_i);
    diff_d  = DiffW'(err_d) - DiffW'(last_err_q);
    p_d     = $signed({1'b0, gains_i.kp}) * err_q;
    i_d     = $signed({1'b0, gains_i.ki}) * err_q;
    dprod_d = $signed({1'b0, gains_i.kd}) * diff_q;
    pd_d    = PdW'(p_q) + PdW'(dprod_q);
    acc_sum = SumW'(integ_q) + SumW'(i_q);
    integ_d = o3wd_pkg::clamp_q8(acc_sum);
    // integ_q holds this item's clamped integral while it sits in stage 3.
    out_sum = SumW'(pd_q) + SumW'(integ_q);
    drive   = o3wd_pkg::clamp_q8(out_sum);
    drive_abs = drive[IntegW-1] ? (IntegW-1)'(-drive) : drive[IntegW-2:0];
    dir_o   = !drive[IntegW-1] && (drive != '0);
    mag_o   = drive_abs[IntegW-2:8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
      integ_q    <= '0;
    end else begin
      if (ctrl_i.ld1) begin
        last_err_q <= err_d;
      end
      if (ctrl_i.ld3) begin
        integ_q <= integ_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld1) begin
      err_q  <= err_d;
      diff_q <= diff_d;
    end
    if (ctrl_i.ld2) begin
      p_q     <= p_d;
      i_q     <= i_d;
      dprod_q <= dprod_d;
    end
    if (ctrl_i.ld3) begin
      pd_q <= pd_d;
    end
  end

endmodule
`default_nettype wire

>>> design/o3wd_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// o3wd_merge: result register
// Gathers the three lanes' direction and magnitude into one result item and
// holds it until the consumer takes it.
// ----------------------------------------------------------------------------
module o3wd_merge (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           load_i,
  input  wire logic                           out_ready_i,
  input  wire logic                           dir_i [o3wd_pkg::Wheels],
  input  wire logic [o3wd_pkg::MagW-1:0]      mag_i [o3wd_pkg::Wheels],
  output logic                                out_valid_o,
  output logic                                dir_o [o3wd_pkg::Wheels],
  output logic [o3wd_pkg::MagW-1:0]           mag_o [o3wd_pkg::Wheels]
);

  logic valid_q;
  logic dir_q [o3wd_pkg::Wheels];
  logic [o3wd_pkg::MagW-1:0] mag_q [o3wd_pkg::Wheels];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= load_i || (valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      dir_q <= dir_i;
      mag_q <= mag_i;
    end
  end

  assign out_valid_o = valid_q;
  assign dir_o       = dir_q;
  assign mag_o       = mag_q;

endmodule
`default_nettype wire

>>> design/omni3_wheel_pid_drive.sv
`default_nettype none
// ----------------------------------------------------------------------------
// omni3_wheel_pid_drive: three-wheel omni kinematics with per-wheel PID
// Flow: a tick item loads stage 1 at the accepting edge, then moves on to
// stages 2 and 3 and the result register, each of which can stall;
// set-velocity items update the setpoints when accepted and give no result.
// Throughput: one item per cycle while the consumer keeps taking results.
// Reset clears gains, setpoints, integrals, last errors and all valid bits.
// ----------------------------------------------------------------------------
module omni3_wheel_pid_drive (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [o3wd_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [o3wd_pkg::GainW-1:0]          cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                operation_i,
  input  wire logic signed [o3wd_pkg::VelW-1:0]    vel_x_i,
  input  wire logic signed [o3wd_pkg::VelW-1:0]    vel_y_i,
  input  wire logic signed [o3wd_pkg::VelW-1:0]    vel_turn_i,
  input  wire logic signed [o3wd_pkg::MeasW-1:0]   meas_a_i,
  input  wire logic signed [o3wd_pkg::MeasW-1:0]   meas_b_i,
  input  wire logic signed [o3wd_pkg::MeasW-1:0]   meas_c_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     dir_a_o,
  output logic                                     dir_b_o,
  output logic                                     dir_c_o,
  output logic [o3wd_pkg::MagW-1:0]                mag_a_o,
  output logic [o3wd_pkg::MagW-1:0]                mag_b_o,
  output logic [o3wd_pkg::MagW-1:0]                mag_c_o
);

  o3wd_pkg::gains_t     gains_q;
  o3wd_pkg::lane_ctrl_t lane_ctrl;
  o3wd_pkg::cfg_reg_e   cfg_reg;

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3, rdy_out;
  logic in_accept, ld_out;

  logic signed [o3wd_pkg::SpW-1:0]   setpoint [o3wd_pkg::Wheels];
  logic signed [o3wd_pkg::MeasW-1:0] meas     [o3wd_pkg::Wheels];
  logic                              lane_dir [o3wd_pkg::Wheels];
  logic [o3wd_pkg::MagW-1:0]         lane_mag [o3wd_pkg::Wheels];
  logic                              res_dir  [o3wd_pkg::Wheels];
  logic [o3wd_pkg::MagW-1:0]         res_mag  [o3wd_pkg::Wheels];

  assign cfg_ready_o = 1'b1;
  assign cfg_reg     = o3wd_pkg::cfg_reg_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg)
        o3wd_pkg::REG_PROP:  gains_q.kp <= cfg_data_i;
        o3wd_pkg::REG_INTEG: gains_q.ki <= cfg_data_i;
        o3wd_pkg::REG_DERIV: gains_q.kd <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Each stage takes a new item when it is empty or its item moves on.
  always_comb begin
    rdy_out   = !out_valid_o || out_ready_i;
    rdy3      = !v3_q || rdy_out;
    rdy2      = !v2_q || rdy3;
    rdy1      = !v1_q || rdy2;
    in_ready_o = rdy1;
    in_accept = in_valid_i && rdy1;
    lane_ctrl.ld1 = in_accept && operation_i;
    lane_ctrl.ld2 = v1_q && rdy2;
    lane_ctrl.ld3 = v2_q && rdy3;
    ld_out        = v3_q && rdy_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= lane_ctrl.ld1 || (v1_q && !lane_ctrl.ld2);
      v2_q <= lane_ctrl.ld2 || (v2_q && !lane_ctrl.ld3);
      v3_q <= lane_ctrl.ld3 || (v3_q && !ld_out);
    end
  end

  o3wd_kin u_kin (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (in_accept && !operation_i),
    .vel_x_i    (vel_x_i),
    .vel_y_i    (vel_y_i),
    .vel_turn_i (vel_turn_i),
    .setpoint_o (setpoint)
  );

  assign meas[0] = meas_a_i;
  assign meas[1] = meas_b_i;
  assign meas[2] = meas_c_i;

  for (genvar g = 0; g < o3wd_pkg::Wheels; g++) begin : g_lane
    o3wd_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (lane_ctrl),
      .gains_i    (gains_q),
      .setpoint_i (setpoint[g]),
      .meas_i     (meas[g]),
      .dir_o      (lane_dir[g]),
      .mag_o      (lane_mag[g])
    );
  end

  o3wd_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (ld_out),
    .out_ready_i (out_ready_i),
    .dir_i       (lane_dir),
    .mag_i       (lane_mag),
    .out_valid_o (out_valid_o),
    .dir_o       (res_dir),
    .mag_o       (res_mag)
  );

  assign dir_a_o = res_dir[0];
  assign dir_b_o = res_dir[1];
  assign dir_c_o = res_dir[2];
  assign mag_a_o = res_mag[0];
  assign mag_b_o = res_mag[1];
  assign mag_c_o = res_mag[2];

endmodule
`default_nettype wire
